FILE: rtl/core/brf_pkg.sv
package brf_pkg;

  // Default ring depth in storage cells; one cell always stays free
  localparam int unsigned DepthDef = 64;

  // Fixed field widths of the transaction payloads
  localparam int unsigned DataW   = 8;
  localparam int unsigned CountW  = 6;
  localparam int unsigned OffsetW = 6;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_DUMP = 2'd3
  } req_e;

  typedef struct packed {
    req_e               req_type;
    logic [DataW-1:0]   data_in;
    logic [OffsetW-1:0] offset;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [DataW-1:0]  data_out;
    logic [CountW-1:0] count;
    logic              is_full;
    logic              is_empty;
    logic              last_of_run;
  } out_t;

endpackage

FILE: rtl/core/brf_ram.sv
module brf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on we, register read data on re; read data holds otherwise
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/brf_ctrl.sv
module brf_ctrl import brf_pkg::*; #(
  parameter int unsigned Depth = DepthDef,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  output logic             ram_we_o,
  output logic             ram_re_o,
  output logic [AW-1:0]    ram_addr_o,
  output logic [DataW-1:0] ram_wdata_o,
  input  logic [DataW-1:0] ram_rdata_i
);

  localparam int unsigned CmpW = (AW > OffsetW) ? AW : OffsetW;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] nxt;
    if (idx == AW'(Depth - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + AW'(1);
    end
    return nxt;
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] widx_q, widx_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] rem_q, rem_d;

  // Read stage: metadata travelling alongside the memory read
  logic          b_vld_q;
  logic          b_ok_q, b_ram_q, b_last_q;
  logic [AW-1:0] b_cnt_q;

  logic          out_vld_q;
  out_t          out_q;

  logic          b_move, a_go, acc, dump_step;
  logic          full, empty, off_ok;
  logic [AW-1:0] off_a, start, total, newest;
  logic [AW:0]   sum;
  logic          issue, i_ok, i_ram, i_last;
  logic          we, re;
  logic [AW-1:0] addr;
  logic [AW:0]   idx_diff;
  logic [AW-1:0] idx_level;

  // Advance the read stage when the output register is free or being taken
  assign b_move     = b_vld_q && (!out_vld_q || out_ready_i);
  assign a_go       = !b_vld_q || b_move;
  assign in_ready_o = (state_q == ST_IDLE) && a_go;
  assign acc        = in_valid_i && in_ready_o;
  assign dump_step  = (state_q == ST_DUMP) && a_go;

  assign full   = (cnt_q == AW'(Depth - 1));
  assign empty  = (cnt_q == '0);
  assign off_ok = CmpW'(in_data_i.offset) < CmpW'(cnt_q);
  assign off_a  = AW'(in_data_i.offset);
  assign sum    = (AW+1)'(ridx_q) + (AW+1)'(off_a);
  assign start  = (sum >= (AW+1)'(Depth)) ? AW'(sum - (AW+1)'(Depth)) : AW'(sum);
  assign total  = cnt_q - off_a;
  assign newest = (widx_q == '0) ? AW'(Depth - 1) : widx_q - AW'(1);

  // Decode the transaction, drive the memory and update indices
  always_comb begin
    state_d = state_q;
    widx_d  = widx_q;
    ridx_d  = ridx_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    issue   = 1'b0;
    i_ok    = 1'b0;
    i_ram   = 1'b0;
    i_last  = 1'b1;
    we      = 1'b0;
    re      = 1'b0;
    addr    = widx_q;
    if (acc) begin
      issue = 1'b1;
      unique case (in_data_i.req_type)
        REQ_PUSH: begin
          if (!full) begin
            we     = 1'b1;
            addr   = widx_q;
            widx_d = wrap_inc(widx_q);
            cnt_d  = cnt_q + AW'(1);
            i_ok   = 1'b1;
          end
        end
        REQ_POP: begin
          if (!empty) begin
            re     = 1'b1;
            addr   = ridx_q;
            ridx_d = wrap_inc(ridx_q);
            cnt_d  = cnt_q - AW'(1);
            i_ok   = 1'b1;
            i_ram  = 1'b1;
          end
        end
        REQ_PEEK: begin
          if (!empty) begin
            re    = 1'b1;
            addr  = newest;
            i_ok  = 1'b1;
            i_ram = 1'b1;
          end
        end
        REQ_DUMP: begin
          if (off_ok) begin
            re     = 1'b1;
            addr   = start;
            i_ok   = 1'b1;
            i_ram  = 1'b1;
            i_last = (total == AW'(1));
            if (total != AW'(1)) begin
              state_d = ST_DUMP;
              pos_d   = wrap_inc(start);
              rem_d   = total - AW'(1);
            end
          end
        end
        default: ;
      endcase
    end else if (dump_step) begin
      issue  = 1'b1;
      re     = 1'b1;
      addr   = pos_q;
      i_ok   = 1'b1;
      i_ram  = 1'b1;
      i_last = (rem_q == AW'(1));
      pos_d  = wrap_inc(pos_q);
      rem_d  = rem_q - AW'(1);
      if (rem_q == AW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  assign ram_we_o    = we;
  assign ram_re_o    = re;
  assign ram_addr_o  = addr;
  assign ram_wdata_o = in_data_i.data_in;

  // Hold state, read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      widx_q    <= '0;
      ridx_q    <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      rem_q     <= '0;
      b_vld_q   <= 1'b0;
      b_ok_q    <= 1'b0;
      b_ram_q   <= 1'b0;
      b_last_q  <= 1'b0;
      b_cnt_q   <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
      ridx_q  <= ridx_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      if (a_go) begin
        b_vld_q <= issue;
        if (issue) begin
          b_ok_q   <= i_ok;
          b_ram_q  <= i_ram;
          b_last_q <= i_last;
          b_cnt_q  <= cnt_d;
        end
      end
      if (b_move) begin
        out_vld_q         <= 1'b1;
        out_q.ok          <= b_ok_q;
        out_q.data_out    <= b_ram_q ? ram_rdata_i : '0;
        out_q.count       <= CountW'(b_cnt_q);
        out_q.is_full     <= (b_cnt_q == AW'(Depth - 1));
        out_q.is_empty    <= (b_cnt_q == '0);
        out_q.last_of_run <= b_last_q;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Fill level recomputed from the indices, for checking
  assign idx_diff  = (AW+1)'(widx_q) + (AW+1)'(Depth) - (AW+1)'(ridx_q);
  assign idx_level = (idx_diff >= (AW+1)'(Depth)) ? AW'(idx_diff - (AW+1)'(Depth))
                                                  : AW'(idx_diff);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= AW'(Depth - 1))
    else $error("fill count beyond capacity");

  a_cnt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == idx_level)
    else $error("fill count disagrees with indices");

  a_dump_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> !in_ready_o)
    else $error("input accepted during dump");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && !b_move) |-> !ram_re_o)
    else $error("memory read issued while read stage stalled");

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !ram_re_o)
    else $error("memory written and read in one cycle");

endmodule

FILE: rtl/core/byte_ring_fifo_unit.sv
// Pipeline: a transaction is accepted and its storage read issued in the same cycle; the read
//   stage then holds it until the output register, which drives out_valid_o, is free or taken.
// Throughput: one push, pop or peek per cycle, back to back, while the output is not stalled.
// A dump reads count-offset bytes, one storage read per byte on the single memory port,
//   and holds off input until the read of its last byte has been issued.
// Reset clears indices, fill count and pipeline; storage is not cleared.
module byte_ring_fifo_unit import brf_pkg::*; #(
  parameter int unsigned Depth = DepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  // Sequencer, read stage and output register
  brf_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // Byte storage
  brf_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
